// ===== sv/arbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio ring DMA block scheduler package
// Shared constants, codes and interface structs for the scheduler core.
// ----------------------------------------------------------------------------
package arbd_pkg;

    // Default sizes for the top-level parameters.
    localparam int RING_BYTES_DEF = 65536;
    localparam int MAX_BLOCK_DEF  = 4096;

    localparam int ADDR_W  = 24;
    localparam int COUNT_W = 12;
    localparam int QUEUE_W = 17;
    localparam int LEN_W   = 17;

    // A DMA block may not cross a 64 KiB page of physical memory.
    localparam logic [LEN_W-1:0] SEG_BYTES = 17'h10000;

    localparam logic [7:0] SILENCE  = 8'd128;
    localparam logic [6:0] VOL_FULL = 7'd100;

    // Truncating divide by 100 for products below 2**14: q = (m * 10486) >> 20.
    localparam int              SCALE_MAG_W = 14;
    localparam logic [13:0]     SCALE_RECIP = 14'd10486;
    localparam int              SCALE_SHIFT = 20;

    typedef enum logic [2:0] {
        ACT_WRITE  = 3'd0,
        ACT_DONE   = 3'd1,
        ACT_PAUSE  = 3'd2,
        ACT_RESUME = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        REG_VOLUME = 2'd0,
        REG_MUTED  = 2'd1,
        REG_BASE   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic               start;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } issue_t;

    typedef struct packed {
        logic playing;
        logic paused;
    } status_t;

endpackage

// ===== sv/arbd_scale.sv =====
// ----------------------------------------------------------------------------
// Volume scaler
// Sample scaling pipeline, registered after the multiply, that produces the ring write port.
// ----------------------------------------------------------------------------
module arbd_scale #(
    parameter int RING_BYTES = arbd_pkg::RING_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(RING_BYTES)-1:0] wr_addr,
    input  logic [7:0]                    sample,
    input  logic [6:0]                    volume,
    input  logic                          muted,
    output logic                          mem_we,
    output logic [$clog2(RING_BYTES)-1:0] mem_waddr,
    output logic [7:0]                    mem_wdata
);

    localparam int PW = $clog2(RING_BYTES);

    logic                                a_valid_reg;
    logic [PW-1:0]                       a_addr_reg;
    logic                                a_bypass_reg;
    logic [7:0]                          a_byp_val_reg;
    logic                                a_neg_reg;
    logic [arbd_pkg::SCALE_MAG_W-1:0]    a_mag_reg;

    logic                                neg;
    logic [7:0]                          mag;
    logic [14:0]                         prod;
    logic [27:0]                         quot_prod;
    logic [7:0]                          quot;

    assign neg  = (sample < arbd_pkg::SILENCE);
    assign mag  = neg ? (arbd_pkg::SILENCE - sample) : (sample - arbd_pkg::SILENCE);
    assign prod = 15'(mag) * 15'(volume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_addr_reg    <= wr_addr;
            a_neg_reg     <= neg;
            // For a volume below 100 the product is at most 128 * 99, so 14 bits hold it.
            a_mag_reg     <= prod[arbd_pkg::SCALE_MAG_W-1:0];
            a_bypass_reg  <= muted || (volume == 7'd0) || (volume >= arbd_pkg::VOL_FULL);
            a_byp_val_reg <= (muted || (volume == 7'd0)) ? arbd_pkg::SILENCE : sample;
        end
    end

    // The quotient is at most 126, so the level stays inside 2..254 and
    // needs no clamp.
    assign quot_prod = 28'(a_mag_reg) * 28'(arbd_pkg::SCALE_RECIP);
    assign quot      = quot_prod[arbd_pkg::SCALE_SHIFT +: 8];

    assign mem_we    = a_valid_reg;
    assign mem_waddr = a_addr_reg;
    assign mem_wdata = a_bypass_reg ? a_byp_val_reg :
                       (a_neg_reg ? (arbd_pkg::SILENCE - quot) : (arbd_pkg::SILENCE + quot));

endmodule

// ===== sv/arbd_ring.sv =====
// ----------------------------------------------------------------------------
// Sample ring memory
// Byte ring with one write port and one registered read port, with
// forwarding of a write that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module arbd_ring #(
    parameter int RING_BYTES = arbd_pkg::RING_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(RING_BYTES)-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [15:0]                   index,
    output logic [7:0]                    rdata
);

    localparam int  PW      = $clog2(RING_BYTES);
    localparam bit  IS_POW2 = ((RING_BYTES & (RING_BYTES - 1)) == 0);

    logic [7:0]    mem [RING_BYTES];
    logic [7:0]    q_reg;
    logic [7:0]    fwd_data_reg;
    logic          fwd_hit_reg;
    logic [PW-1:0] raddr;

    generate
        if (IS_POW2)
        begin : g_mask
            assign raddr = index[PW-1:0];
        end
        else
        begin : g_recip
            // Exact quotient for a 16-bit index while it fits the 8-bit quo: 2**32 / RING_BYTES rounded up.
            localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(RING_BYTES) - 64'd1)
                                                / 64'(RING_BYTES));
            logic [48:0] qprod;
            logic [7:0]  quo;
            logic [16:0] rem;
            assign qprod = 49'(index) * 49'(RECIP);
            assign quo   = qprod[39:32];
            assign rem   = 17'(index) - 17'(quo) * 17'(RING_BYTES);
            assign raddr = rem[PW-1:0];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg        <= mem[raddr];
            fwd_hit_reg  <= we && (waddr == raddr);
            fwd_data_reg <= wdata;
        end
    end

    assign rdata = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

// ===== sv/arbd_sched.sv =====
// ----------------------------------------------------------------------------
// Ring pointer and DMA block scheduler
// Holds the ring pointers and playback flags and decides block issue.
// ----------------------------------------------------------------------------
module arbd_sched #(
    parameter int RING_BYTES = arbd_pkg::RING_BYTES_DEF,
    parameter int MAX_BLOCK  = arbd_pkg::MAX_BLOCK_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [2:0]                      action,
    input  logic                            end_of_write,
    input  logic [arbd_pkg::ADDR_W-1:0]     ring_base,
    output logic                            wr_ok,
    output logic [$clog2(RING_BYTES)-1:0]   wr_pos,
    output arbd_pkg::issue_t                issue,
    output logic [$clog2(RING_BYTES+1)-1:0] fill_next,
    output arbd_pkg::status_t               status_next
);

    localparam int PW = $clog2(RING_BYTES);
    localparam int CW = $clog2(RING_BYTES + 1);
    localparam int LW = arbd_pkg::LEN_W;

    localparam logic [CW-1:0] FILL_FULL = CW'(RING_BYTES);
    localparam logic [LW-1:0] RING_LEN  = LW'(RING_BYTES);
    localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_BLOCK);
    localparam logic [PW-1:0] POS_LAST  = PW'(RING_BYTES - 1);

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] fill_reg, fill_mid;
    logic          flight_reg, flight_next;
    logic          pause_reg, pause_next;

    logic [PW-1:0]               wp_mid;
    logic                        try_en;
    logic                        t_pause;
    logic                        t_flight;
    logic                        can_issue;
    logic [arbd_pkg::ADDR_W-1:0] phys;
    logic [LW-1:0]               seg_left;
    logic [LW-1:0]               to_end;
    logic [LW-1:0]               n1, n2, n;
    logic [LW-1:0]               rp_sum;
    logic [CW-1:0]               fill_out;

    assign wr_ok  = (fill_reg != FILL_FULL);
    assign wr_pos = wp_reg;

    always_comb
    begin
        wp_mid   = wp_reg;
        fill_mid = fill_reg;
        t_pause  = pause_reg;
        t_flight = flight_reg;
        try_en   = 1'b0;
        unique case (action)
            arbd_pkg::ACT_WRITE:
            begin
                if (wr_ok)
                begin
                    wp_mid   = (wp_reg == POS_LAST) ? '0 : wp_reg + PW'(1);
                    fill_mid = fill_reg + CW'(1);
                end
                try_en = end_of_write || (wp_mid == '0) || (fill_mid == FILL_FULL);
            end
            arbd_pkg::ACT_DONE:
            begin
                t_flight = 1'b0;
                try_en   = 1'b1;
            end
            arbd_pkg::ACT_RESUME:
            begin
                t_pause = 1'b0;
                try_en  = 1'b1;
            end
            default:
            begin
            end
        endcase

        phys      = ring_base + arbd_pkg::ADDR_W'(rp_reg);
        can_issue = try_en && !t_pause && !t_flight && (fill_mid != '0) && (phys != '0);

        seg_left = arbd_pkg::SEG_BYTES - LW'(phys[15:0]);
        to_end   = RING_LEN - LW'(rp_reg);
        n1       = (LW'(fill_mid) < MAX_LEN) ? LW'(fill_mid) : MAX_LEN;
        n2       = (n1 < seg_left) ? n1 : seg_left;
        n        = (n2 < to_end) ? n2 : to_end;
        rp_sum   = LW'(rp_reg) + n;

        issue.start = can_issue;
        issue.addr  = can_issue ? phys : '0;
        issue.count = can_issue ? 12'(n - LW'(1)) : '0;

        wp_next     = wp_mid;
        rp_next     = rp_reg;
        fill_out    = fill_mid;
        flight_next = t_flight;
        pause_next  = t_pause;
        if (can_issue)
        begin
            rp_next     = (rp_sum == RING_LEN) ? '0 : rp_sum[PW-1:0];
            fill_out    = fill_mid - CW'(n);
            flight_next = 1'b1;
        end

        priority if (action == arbd_pkg::ACT_PAUSE)
        begin
            pause_next = 1'b1;
        end
        else if (action == arbd_pkg::ACT_STOP)
        begin
            pause_next  = 1'b1;
            flight_next = 1'b0;
            wp_next     = '0;
            rp_next     = '0;
            fill_out    = '0;
        end
        else
        begin
        end
    end

    assign fill_next           = fill_out;
    assign status_next.playing = flight_next;
    assign status_next.paused  = pause_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            fill_reg   <= '0;
            flight_reg <= 1'b0;
            pause_reg  <= 1'b0;
        end
        else if (step)
        begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            fill_reg   <= fill_out;
            flight_reg <= flight_next;
            pause_reg  <= pause_next;
        end
    end

endmodule

// ===== sv/audio_ring_dma_block_scheduler_core.sv =====
// The result of an item is registered and offered in the cycle after the transfer.
// Throughput: one item per cycle; the input is ready whenever the result register is
// empty or is being emptied in the same cycle.
// A stored sample is registered in the multiply stage before it reaches the ring memory.
// Reset (rst_n, asynchronous, active low) clears pointers, flags and valid bits, and
// sets config defaults; ring contents stay undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
// Audio ring DMA block scheduler core
// Volume-scaled sample ring with DMA block issue and an APB register port.
// ----------------------------------------------------------------------------
module audio_ring_dma_block_scheduler_core #(
    parameter int RING_BYTES = arbd_pkg::RING_BYTES_DEF,
    parameter int MAX_BLOCK  = arbd_pkg::MAX_BLOCK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           action,
    input  logic [7:0]                           sample,
    input  logic                                 end_of_write,
    input  logic [15:0]                          entry_index,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accepted,
    output logic                                 block_start,
    output logic [arbd_pkg::ADDR_W-1:0]          block_addr,
    output logic [arbd_pkg::COUNT_W-1:0]         block_count,
    output logic [arbd_pkg::QUEUE_W-1:0]         queued,
    output logic                                 playing_now,
    output logic                                 paused_now,
    output logic [7:0]                           read_data
);

    localparam int PW = $clog2(RING_BYTES);
    localparam int CW = $clog2(RING_BYTES + 1);

    logic [6:0]                  volume_reg;
    logic                        muted_reg;
    logic [arbd_pkg::ADDR_W-1:0] base_reg;
    logic                        cfg_write;

    logic                        step;
    logic                        wr_ok;
    logic [PW-1:0]               wr_pos;
    arbd_pkg::issue_t            issue;
    logic [CW-1:0]               fill_next;
    arbd_pkg::status_t           status_next;

    logic                        mem_we;
    logic [PW-1:0]               mem_waddr;
    logic [7:0]                  mem_wdata;
    logic [7:0]                  mem_rdata;
    logic                        is_write;
    logic                        is_read;

    logic                        out_valid_reg;
    logic                        accepted_reg;
    arbd_pkg::issue_t            issue_reg;
    logic [CW-1:0]               queued_reg;
    arbd_pkg::status_t           status_reg;
    logic                        is_read_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= arbd_pkg::VOL_FULL;
            muted_reg  <= 1'b0;
            base_reg   <= 24'h010000;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                arbd_pkg::REG_VOLUME: volume_reg <= pwdata[6:0];
                arbd_pkg::REG_MUTED:  muted_reg  <= pwdata[0];
                arbd_pkg::REG_BASE:   base_reg   <= pwdata[arbd_pkg::ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            arbd_pkg::REG_VOLUME: prdata = 32'(volume_reg);
            arbd_pkg::REG_MUTED:  prdata = 32'(muted_reg);
            arbd_pkg::REG_BASE:   prdata = 32'(base_reg);
            default:              prdata = '0;
        endcase
    end

    // Item flow
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;
    assign is_write = (action == arbd_pkg::ACT_WRITE);
    assign is_read  = (action == arbd_pkg::ACT_READ);

    arbd_sched #(
        .RING_BYTES (RING_BYTES),
        .MAX_BLOCK  (MAX_BLOCK)
    ) u_sched (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .action       (action),
        .end_of_write (end_of_write),
        .ring_base    (base_reg),
        .wr_ok        (wr_ok),
        .wr_pos       (wr_pos),
        .issue        (issue),
        .fill_next    (fill_next),
        .status_next  (status_next)
    );

    arbd_scale #(
        .RING_BYTES (RING_BYTES)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (step && is_write && wr_ok),
        .wr_addr   (wr_pos),
        .sample    (sample),
        .volume    (volume_reg),
        .muted     (muted_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    arbd_ring #(
        .RING_BYTES (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (step && is_read),
        .index (entry_index),
        .rdata (mem_rdata)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            accepted_reg <= is_write && wr_ok;
            issue_reg    <= issue;
            queued_reg   <= fill_next;
            status_reg   <= status_next;
            is_read_reg  <= is_read;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign block_start = issue_reg.start;
    assign block_addr  = issue_reg.addr;
    assign block_count = issue_reg.count;
    assign queued      = arbd_pkg::QUEUE_W'(queued_reg);
    assign playing_now = status_reg.playing;
    assign paused_now  = status_reg.paused;
    assign read_data   = is_read_reg ? mem_rdata : 8'd0;

    // Checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (queued <= arbd_pkg::QUEUE_W'(RING_BYTES)))
        else $error("queued byte count exceeds the ring size");

    a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && block_start) |-> (playing_now && !paused_now && block_addr != '0))
        else $error("block issued while paused, idle or at address zero");

    a_no_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !block_start) |-> (block_addr == '0 && block_count == '0))
        else $error("block fields set without a block issue");

    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_read_reg) |-> (!accepted && !block_start))
        else $error("ring read result also reports a write or a block issue");

endmodule
